@@ rtl/core/tsjs_pkg.sv @@
package tsjs_pkg;

   localparam logic [2:0] KIND_CREATE  = 3'd0;
   localparam logic [2:0] KIND_TICK    = 3'd1;
   localparam logic [2:0] KIND_YIELD   = 3'd2;
   localparam logic [2:0] KIND_JOIN    = 3'd3;
   localparam logic [2:0] KIND_EXIT    = 3'd4;
   localparam logic [2:0] KIND_SUSPEND = 3'd5;
   localparam logic [2:0] KIND_RESUME  = 3'd6;

   localparam logic [2:0] RS_OK        = 3'd0;
   localparam logic [2:0] RS_JOIN_DONE = 3'd1;
   localparam logic [2:0] RS_JOIN_WAIT = 3'd2;
   localparam logic [2:0] RS_NOT_FOUND = 3'd3;
   localparam logic [2:0] RS_IDS_OUT   = 3'd4;
   localparam logic [2:0] RS_NO_READY  = 3'd5;
   localparam logic [2:0] RS_DELIVERED = 3'd6;

   localparam logic [2:0] TH_ABSENT   = 3'd0;
   localparam logic [2:0] TH_RUNNING  = 3'd1;
   localparam logic [2:0] TH_READY    = 3'd2;
   localparam logic [2:0] TH_BLOCKED  = 3'd3;
   localparam logic [2:0] TH_FINISHED = 3'd4;
   localparam logic [2:0] TH_REAPED   = 3'd5;

   typedef enum logic [2:0] {
      TS_CUR,
      TS_CUR0,
      TS_TGT,
      TS_NEW,
      TS_WAIT,
      TS_HEAD
   } tid_src_type;

   typedef struct packed {
      logic        latch;
      logic        idx_clr;
      logic        idx_inc;
      logic        sel;
      logic        mode;
      logic        list_rd;
      logic        list_nxt;
      logic        list_shift;
      logic        cnt_dec;
      logic        rdy_push;
      tid_src_type rdy_src;
      logic        blk_push;
      tid_src_type blk_src;
      logic        blk_join;
      logic        st_rd;
      tid_src_type st_rd_src;
      logic        st_wr;
      tid_src_type st_wr_src;
      logic [2:0]  st_val;
      logic        fin_rd;
      logic        fin_set;
      logic        fin_clr;
      logic        q_rd;
      logic        q_tgt;
      logic        q_inc;
      logic        hi_inc;
      logic        cur_load;
      logic        wait_cap;
      logic        set_code;
      logic [2:0]  code;
      logic        set_sub_new;
      logic        set_jv;
      logic        out_load;
      logic        out_second;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       tgt_is_cur;
      logic       rdy_empty;
      logic       ids_full;
      logic [2:0] st_q;
      logic       fin_ok;
      logic       match;
      logic       scan_end;
      logic       rm_end;
      logic       out_free;
   } stat_type;

endpackage

@@ rtl/core/tsjs_dp.sv @@
module tsjs_dp import tsjs_pkg::*; #(
   parameter int ID_LIMIT = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [2:0]         req_kind,
   input  logic [5:0]         req_target_tid,
   input  logic [63:0]        req_exit_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_running_tid,
   output logic [5:0]         rsp_subject_tid,
   output logic [63:0]        rsp_join_value,
   output logic signed [32:0] rsp_subject_quantums,
   output logic [31:0]        rsp_total_quantums,
   output logic               rsp_last
);

   localparam logic [5:0] LimitId = 6'(ID_LIMIT);

   logic [2:0]  kind_ff;
   logic [5:0]  tgt_ff;
   logic [63:0] val_ff;
   logic [5:0]  cur_ff;
   logic [5:0]  cur0_ff;
   logic [5:0]  hi_ff;
   logic [6:0]  rc_ff;
   logic [6:0]  bc_ff;
   logic [31:0] tot_ff;
   logic [6:0]  idx_ff;
   logic [5:0]  wait_ff;
   logic [2:0]  code_ff;
   logic [5:0]  sub_ff;
   logic [63:0] jv_ff;

   logic [5:0]  rdy_mem_ff [64];
   logic [12:0] blk_mem_ff [64];
   logic [2:0]  st_mem_ff  [64];
   logic [31:0] q_mem_ff   [64];
   logic [63:0] fin_mem_ff [64];
   logic [63:0] st_vld_ff;
   logic [63:0] q_vld_ff;
   logic [63:0] fin_vld_ff;

   logic [5:0]  rdy_q_ff;
   logic [12:0] blk_q_ff;
   logic [2:0]  st_q_ff;
   logic [31:0] q_q_ff;
   logic [63:0] fin_q_ff;
   logic        fin_ok_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [5:0]  rsp_running_ff;
   logic [5:0]  rsp_subject_ff;
   logic [63:0] rsp_jv_ff;
   logic [32:0] rsp_q_ff;
   logic [31:0] rsp_tot_ff;
   logic        rsp_last_ff;

   logic [5:0]  new_tid;
   logic [5:0]  rdy_tid;
   logic [5:0]  blk_tid;
   logic [5:0]  st_rd_tid;
   logic [5:0]  st_wr_tid;
   logic [5:0]  q_addr;
   logic [5:0]  list_addr;
   logic [6:0]  cnt_sel;
   logic        rdy_push_ok;
   logic        blk_push_ok;
   logic        out_free;
   logic [6:0]  rc_in;
   logic [6:0]  bc_in;

   function automatic logic [5:0] pick(input tid_src_type s, input logic [5:0] cur,
                                       input logic [5:0] cur0, input logic [5:0] tgt,
                                       input logic [5:0] nw, input logic [5:0] wt,
                                       input logic [5:0] head);
      logic [5:0] r;
      unique case (s)
         TS_CUR:  r = cur;
         TS_CUR0: r = cur0;
         TS_TGT:  r = tgt;
         TS_NEW:  r = nw;
         TS_WAIT: r = wt;
         TS_HEAD: r = head;
         default: r = cur;
      endcase
      return r;
   endfunction

   assign new_tid   = hi_ff + 6'd1;
   assign rdy_tid   = pick(cmd.rdy_src, cur_ff, cur0_ff, tgt_ff, new_tid, wait_ff, rdy_q_ff);
   assign blk_tid   = pick(cmd.blk_src, cur_ff, cur0_ff, tgt_ff, new_tid, wait_ff, rdy_q_ff);
   assign st_rd_tid = pick(cmd.st_rd_src, cur_ff, cur0_ff, tgt_ff, new_tid, wait_ff, rdy_q_ff);
   assign st_wr_tid = pick(cmd.st_wr_src, cur_ff, cur0_ff, tgt_ff, new_tid, wait_ff, rdy_q_ff);
   assign q_addr    = cmd.q_tgt ? tgt_ff : cur0_ff;
   assign list_addr = cmd.list_nxt ? (idx_ff[5:0] + 6'd1) : idx_ff[5:0];
   assign cnt_sel   = cmd.sel ? bc_ff : rc_ff;
   assign rdy_push_ok = cmd.rdy_push && (rc_ff != 7'd64);
   assign blk_push_ok = cmd.blk_push && (bc_ff != 7'd64);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rc_in = rc_ff;
      bc_in = bc_ff;
      if (rdy_push_ok) begin
         rc_in = rc_ff + 7'd1;
      end else if (cmd.cnt_dec && !cmd.sel) begin
         rc_in = rc_ff - 7'd1;
      end
      if (blk_push_ok) begin
         bc_in = bc_ff + 7'd1;
      end else if (cmd.cnt_dec && cmd.sel) begin
         bc_in = bc_ff - 7'd1;
      end
   end

   always_comb begin
      stat.kind       = kind_ff;
      stat.tgt_is_cur = (tgt_ff == cur0_ff);
      stat.rdy_empty  = (rc_ff == 7'd0);
      stat.ids_full   = (hi_ff >= LimitId);
      stat.st_q       = st_q_ff;
      stat.fin_ok     = fin_ok_ff;
      if (cmd.sel) begin
         stat.match = cmd.mode ? (blk_q_ff[6] && (blk_q_ff[5:0] == cur0_ff))
                               : (blk_q_ff[12:7] == tgt_ff);
      end else begin
         stat.match = (rdy_q_ff == tgt_ff);
      end
      stat.scan_end = (idx_ff == cnt_sel);
      stat.rm_end   = ((idx_ff + 7'd1) >= cnt_sel);
      stat.out_free = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         hi_ff        <= '0;
         rc_ff        <= '0;
         bc_ff        <= '0;
         tot_ff       <= '0;
         st_vld_ff    <= '0;
         q_vld_ff     <= '0;
         fin_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rc_ff <= rc_in;
         bc_ff <= bc_in;
         if (cmd.cur_load) begin
            cur_ff <= rdy_q_ff;
         end
         if (cmd.hi_inc) begin
            hi_ff <= new_tid;
         end
         if (cmd.q_inc) begin
            q_vld_ff[cur0_ff] <= 1'b1;
            if (tot_ff != 32'hFFFF_FFFF) begin
               tot_ff <= tot_ff + 32'd1;
            end
         end
         if (cmd.st_wr) begin
            st_vld_ff[st_wr_tid] <= 1'b1;
         end
         if (cmd.fin_set) begin
            fin_vld_ff[cur0_ff] <= 1'b1;
         end else if (cmd.fin_clr) begin
            fin_vld_ff[tgt_ff] <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         tgt_ff  <= req_target_tid;
         val_ff  <= req_exit_value;
         cur0_ff <= cur_ff;
         code_ff <= RS_OK;
         sub_ff  <= req_target_tid;
         jv_ff   <= '0;
      end
      if (cmd.set_code) begin
         code_ff <= cmd.code;
      end
      if (cmd.set_sub_new) begin
         sub_ff <= new_tid;
      end
      if (cmd.set_jv) begin
         jv_ff <= fin_q_ff;
      end
      if (cmd.wait_cap) begin
         wait_ff <= blk_q_ff[12:7];
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 7'd1;
      end

      if (rdy_push_ok) begin
         rdy_mem_ff[rc_ff[5:0]] <= rdy_tid;
      end else if (cmd.list_shift && !cmd.sel) begin
         rdy_mem_ff[idx_ff[5:0]] <= rdy_q_ff;
      end
      if (cmd.list_rd && !cmd.sel) begin
         rdy_q_ff <= rdy_mem_ff[list_addr];
      end

      if (blk_push_ok) begin
         blk_mem_ff[bc_ff[5:0]] <= {blk_tid, cmd.blk_join, cmd.blk_join ? tgt_ff : 6'd0};
      end else if (cmd.list_shift && cmd.sel) begin
         blk_mem_ff[idx_ff[5:0]] <= blk_q_ff;
      end
      if (cmd.list_rd && cmd.sel) begin
         blk_q_ff <= blk_mem_ff[list_addr];
      end

      if (cmd.st_wr) begin
         st_mem_ff[st_wr_tid] <= cmd.st_val;
      end
      if (cmd.st_rd) begin
         if (st_vld_ff[st_rd_tid]) begin
            st_q_ff <= st_mem_ff[st_rd_tid];
         end else begin
            st_q_ff <= (st_rd_tid == 6'd0) ? TH_RUNNING : TH_ABSENT;
         end
      end

      if (cmd.fin_set) begin
         fin_mem_ff[cur0_ff] <= val_ff;
      end
      if (cmd.fin_rd) begin
         fin_q_ff  <= fin_mem_ff[tgt_ff];
         fin_ok_ff <= fin_vld_ff[tgt_ff];
      end

      if (cmd.q_inc) begin
         q_mem_ff[cur0_ff] <= (q_q_ff == 32'hFFFF_FFFF) ? q_q_ff : q_q_ff + 32'd1;
      end
      if (cmd.q_rd) begin
         q_q_ff <= q_vld_ff[q_addr] ? q_mem_ff[q_addr] : 32'd0;
      end

      if (cmd.out_load) begin
         rsp_status_ff  <= cmd.out_second ? RS_DELIVERED : code_ff;
         rsp_running_ff <= cur_ff;
         rsp_subject_ff <= cmd.out_second ? wait_ff : sub_ff;
         rsp_jv_ff      <= cmd.out_second ? val_ff : jv_ff;
         rsp_q_ff       <= (tgt_ff <= hi_ff) ? {1'b0, q_q_ff} : {33{1'b1}};
         rsp_tot_ff     <= tot_ff;
         rsp_last_ff    <= cmd.out_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_running_tid      = rsp_running_ff;
   assign rsp_subject_tid      = rsp_subject_ff;
   assign rsp_join_value       = rsp_jv_ff;
   assign rsp_subject_quantums = $signed(rsp_q_ff);
   assign rsp_total_quantums   = rsp_tot_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

@@ rtl/core/tsjs_ctrl.sv @@
module tsjs_ctrl import tsjs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISP,
      S_TICK_WR,
      S_SW_RD,
      S_SW_CK,
      S_SW_HD_RD,
      S_SW_HD,
      S_JOIN_CK,
      S_EXIT_CK,
      S_EXIT_W,
      S_EXIT_MK,
      S_SUSP_CK,
      S_SUSP_B,
      S_RES_CK,
      S_RES_B,
      S_SCAN_RD,
      S_SCAN_CK,
      S_RM_RD,
      S_RM_WR,
      S_EMIT_RD,
      S_EMIT_WT,
      S_EMIT2
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      sel_ff, sel_in;
   logic      mode_ff, mode_in;
   logic      found_ff, found_in;
   logic      two;

   assign two  = found_ff && (stat.kind == KIND_EXIT);
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.sel  = sel_ff;
      cmd.mode = mode_ff;
      state_in = state_ff;
      ret_in   = ret_ff;
      sel_in   = sel_ff;
      mode_in  = mode_ff;
      found_in = found_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               found_in  = 1'b0;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.kind)
               KIND_CREATE: begin
                  if (stat.ids_full) begin
                     cmd.set_code = 1'b1;
                     cmd.code     = RS_IDS_OUT;
                  end else begin
                     cmd.hi_inc      = 1'b1;
                     cmd.st_wr       = 1'b1;
                     cmd.st_wr_src   = TS_NEW;
                     cmd.st_val      = TH_READY;
                     cmd.rdy_push    = 1'b1;
                     cmd.rdy_src     = TS_NEW;
                     cmd.set_sub_new = 1'b1;
                  end
                  state_in = S_EMIT_RD;
               end
               KIND_TICK: begin
                  cmd.q_rd = 1'b1;
                  state_in = S_TICK_WR;
               end
               KIND_YIELD: begin
                  state_in = S_SW_RD;
               end
               KIND_JOIN: begin
                  cmd.st_rd     = 1'b1;
                  cmd.st_rd_src = TS_TGT;
                  cmd.fin_rd    = 1'b1;
                  state_in      = S_JOIN_CK;
               end
               KIND_EXIT: begin
                  cmd.idx_clr = 1'b1;
                  sel_in      = 1'b1;
                  mode_in     = 1'b1;
                  ret_in      = S_EXIT_CK;
                  state_in    = S_SCAN_RD;
               end
               KIND_SUSPEND: begin
                  if (stat.tgt_is_cur) begin
                     if (stat.rdy_empty) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = RS_NO_READY;
                        state_in     = S_EMIT_RD;
                     end else begin
                        cmd.st_wr     = 1'b1;
                        cmd.st_wr_src = TS_CUR0;
                        cmd.st_val    = TH_BLOCKED;
                        cmd.blk_push  = 1'b1;
                        cmd.blk_src   = TS_CUR0;
                        state_in      = S_SW_RD;
                     end
                  end else begin
                     cmd.idx_clr = 1'b1;
                     sel_in      = 1'b0;
                     mode_in     = 1'b0;
                     ret_in      = S_SUSP_CK;
                     state_in    = S_SCAN_RD;
                  end
               end
               KIND_RESUME: begin
                  cmd.idx_clr = 1'b1;
                  sel_in      = 1'b1;
                  mode_in     = 1'b0;
                  ret_in      = S_RES_CK;
                  state_in    = S_SCAN_RD;
               end
               default: begin
                  state_in = S_EMIT_RD;
               end
            endcase
         end
         S_TICK_WR: begin
            cmd.q_inc = 1'b1;
            state_in  = S_SW_RD;
         end
         S_SW_RD: begin
            cmd.st_rd     = 1'b1;
            cmd.st_rd_src = TS_CUR;
            state_in      = S_SW_CK;
         end
         S_SW_CK: begin
            sel_in      = 1'b0;
            cmd.idx_clr = 1'b1;
            if (stat.st_q == TH_RUNNING) begin
               cmd.st_wr     = 1'b1;
               cmd.st_wr_src = TS_CUR;
               cmd.st_val    = TH_READY;
               cmd.rdy_push  = 1'b1;
               cmd.rdy_src   = TS_CUR;
               state_in      = S_SW_HD_RD;
            end else if (stat.rdy_empty) begin
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_SW_HD_RD;
            end
         end
         S_SW_HD_RD: begin
            cmd.list_rd = 1'b1;
            state_in    = S_SW_HD;
         end
         S_SW_HD: begin
            cmd.cur_load  = 1'b1;
            cmd.st_wr     = 1'b1;
            cmd.st_wr_src = TS_HEAD;
            cmd.st_val    = TH_RUNNING;
            ret_in        = S_EMIT_RD;
            state_in      = S_RM_RD;
         end
         S_JOIN_CK: begin
            state_in = S_EMIT_RD;
            if (stat.st_q == TH_FINISHED && stat.fin_ok) begin
               cmd.set_jv    = 1'b1;
               cmd.fin_clr   = 1'b1;
               cmd.st_wr     = 1'b1;
               cmd.st_wr_src = TS_TGT;
               cmd.st_val    = TH_REAPED;
               cmd.set_code  = 1'b1;
               cmd.code      = RS_JOIN_DONE;
            end else if (stat.st_q == TH_READY || stat.st_q == TH_BLOCKED) begin
               cmd.set_code = 1'b1;
               if (stat.rdy_empty) begin
                  cmd.code = RS_NO_READY;
               end else begin
                  cmd.code      = RS_JOIN_WAIT;
                  cmd.st_wr     = 1'b1;
                  cmd.st_wr_src = TS_CUR0;
                  cmd.st_val    = TH_BLOCKED;
                  cmd.blk_push  = 1'b1;
                  cmd.blk_src   = TS_CUR0;
                  cmd.blk_join  = 1'b1;
                  state_in      = S_SW_RD;
               end
            end else begin
               cmd.set_code = 1'b1;
               cmd.code     = RS_NOT_FOUND;
            end
         end
         S_EXIT_CK: begin
            if (!found_ff && stat.rdy_empty) begin
               cmd.set_code = 1'b1;
               cmd.code     = RS_NO_READY;
               state_in     = S_EMIT_RD;
            end else if (found_ff) begin
               cmd.wait_cap = 1'b1;
               ret_in       = S_EXIT_W;
               state_in     = S_RM_RD;
            end else begin
               state_in = S_EXIT_MK;
            end
         end
         S_EXIT_W: begin
            cmd.rdy_push  = 1'b1;
            cmd.rdy_src   = TS_WAIT;
            cmd.st_wr     = 1'b1;
            cmd.st_wr_src = TS_WAIT;
            cmd.st_val    = TH_READY;
            state_in      = S_EXIT_MK;
         end
         S_EXIT_MK: begin
            cmd.st_wr     = 1'b1;
            cmd.st_wr_src = TS_CUR0;
            if (found_ff) begin
               cmd.st_val = TH_REAPED;
            end else begin
               cmd.st_val  = TH_FINISHED;
               cmd.fin_set = 1'b1;
            end
            state_in = S_SW_RD;
         end
         S_SUSP_CK: begin
            if (found_ff) begin
               ret_in   = S_SUSP_B;
               state_in = S_RM_RD;
            end else begin
               cmd.set_code = 1'b1;
               cmd.code     = RS_NOT_FOUND;
               state_in     = S_EMIT_RD;
            end
         end
         S_SUSP_B: begin
            cmd.st_wr     = 1'b1;
            cmd.st_wr_src = TS_TGT;
            cmd.st_val    = TH_BLOCKED;
            cmd.blk_push  = 1'b1;
            cmd.blk_src   = TS_TGT;
            state_in      = S_EMIT_RD;
         end
         S_RES_CK: begin
            if (found_ff) begin
               ret_in   = S_RES_B;
               state_in = S_RM_RD;
            end else begin
               cmd.set_code = 1'b1;
               cmd.code     = RS_NOT_FOUND;
               state_in     = S_EMIT_RD;
            end
         end
         S_RES_B: begin
            cmd.rdy_push  = 1'b1;
            cmd.rdy_src   = TS_TGT;
            cmd.st_wr     = 1'b1;
            cmd.st_wr_src = TS_TGT;
            cmd.st_val    = TH_READY;
            state_in      = S_EMIT_RD;
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               found_in = 1'b0;
               state_in = ret_ff;
            end else begin
               cmd.list_rd = 1'b1;
               state_in    = S_SCAN_CK;
            end
         end
         S_SCAN_CK: begin
            if (stat.match) begin
               found_in = 1'b1;
               state_in = ret_ff;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_RM_RD: begin
            if (stat.rm_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ret_ff;
            end else begin
               cmd.list_rd  = 1'b1;
               cmd.list_nxt = 1'b1;
               state_in     = S_RM_WR;
            end
         end
         S_RM_WR: begin
            cmd.list_shift = 1'b1;
            cmd.idx_inc    = 1'b1;
            state_in       = S_RM_RD;
         end
         S_EMIT_RD: begin
            cmd.q_rd  = 1'b1;
            cmd.q_tgt = 1'b1;
            state_in  = S_EMIT_WT;
         end
         S_EMIT_WT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = !two;
               state_in     = two ? S_EMIT2 : S_IDLE;
            end
         end
         S_EMIT2: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_second = 1'b1;
               cmd.out_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         sel_ff   <= 1'b0;
         mode_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         sel_ff   <= sel_in;
         mode_ff  <= mode_in;
         found_ff <= found_in;
      end
   end

endmodule

@@ rtl/core/thread_scheduler_join_suspend.sv @@
// Round-robin thread scheduler with join, exit, suspend and resume; thread 0 runs after
// reset. One item is taken at a time, and req_stall stays high until its last result is
// in the output register, so the next item may enter while that result still waits. An
// item walks the ready or blocked list one entry at a time when it scans or closes it up:
// a scan step reads one entry, and a close-up step reads the next entry and writes it one
// place earlier. A yield takes the ready list's head and closes up that list; a tick first
// adds a quantum. An exit scans the blocked list, closes it up on a waiter and switches.
module thread_scheduler_join_suspend import tsjs_pkg::*; #(
   parameter int MAX_THREADS = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic [5:0]         req_target_tid,
   input  logic [63:0]        req_exit_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_running_tid,
   output logic [5:0]         rsp_subject_tid,
   output logic [63:0]        rsp_join_value,
   output logic signed [32:0] rsp_subject_quantums,
   output logic [31:0]        rsp_total_quantums,
   output logic               rsp_last
);

   localparam int IdLimit = (MAX_THREADS < 63) ? MAX_THREADS : 63;

   cmd_type  cmd;
   stat_type stat;
   logic     busy;

   assign req_stall = busy;

   tsjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd)
   );

   tsjs_dp #(
      .ID_LIMIT (IdLimit)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_kind             (req_kind),
      .req_target_tid       (req_target_tid),
      .req_exit_value       (req_exit_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_running_tid      (rsp_running_tid),
      .rsp_subject_tid      (rsp_subject_tid),
      .rsp_join_value       (rsp_join_value),
      .rsp_subject_quantums (rsp_subject_quantums),
      .rsp_total_quantums   (rsp_total_quantums),
      .rsp_last             (rsp_last)
   );

endmodule

@@ rtl/core/tsjs_checker.sv @@
module tsjs_checker import tsjs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_kind,
   input logic [5:0]         req_target_tid,
   input logic [63:0]        req_exit_value,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic [5:0]         rsp_running_tid,
   input logic [5:0]         rsp_subject_tid,
   input logic [63:0]        rsp_join_value,
   input logic signed [32:0] rsp_subject_quantums,
   input logic [31:0]        rsp_total_quantums,
   input logic               rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_join_value) && $stable(rsp_last))
      else $error("stalled item changed");

   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && rsp_last
         && rsp_status == RS_DELIVERED)
      else $error("delivery item does not follow first exit item");

   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == RS_OK && rsp_join_value == 64'd0)
      else $error("first exit item malformed");

   a_deliver: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == RS_DELIVERED |-> rsp_last)
      else $error("delivery not last");

   a_quant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_subject_quantums[32] || (&rsp_subject_quantums))
      else $error("quantum count out of range");

endmodule

bind thread_scheduler_join_suspend tsjs_checker u_chk (.*);
